>>> hdl/orsa_pkg.sv
// Shared types, widths, register codes and controller encodings for the
// outlier-rejecting sample average. No dependencies.
`timescale 1ns / 1ps

package orsa_pkg;

   // converter sample width and the longest run that is ever averaged
   localparam int SAMPLE_BITS   = 12;
   localparam int RUN_LIMIT     = 8;
   localparam int COUNT_BITS    = 4;
   localparam int SUM_BITS      = SAMPLE_BITS + $clog2(RUN_LIMIT);
   localparam int TAKEN_BITS    = 8;
   localparam int PCT_BITS      = 8;
   localparam int LOWER_BITS    = 7;
   localparam int PCT_SCALE     = 100;

   // count*100 and the cross-multiplied products of the band test
   localparam int SCALE_BITS    = COUNT_BITS + 7;
   localparam int PROD_BITS     = SAMPLE_BITS + 1 + SCALE_BITS;

   // radix-4 restoring divider: two quotient bits per cycle
   localparam int DIV_BITS      = SUM_BITS + (SUM_BITS % 2);
   localparam int DIV_CYCLES    = DIV_BITS / 2;
   localparam int DIV_CNT_BITS  = $clog2(DIV_CYCLES);

   // configuration port
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 8;

   typedef logic [SAMPLE_BITS-1:0]   sample_type;
   typedef logic [COUNT_BITS-1:0]    count_type;
   typedef logic [SUM_BITS-1:0]      sum_type;
   typedef logic [TAKEN_BITS-1:0]    taken_type;
   typedef logic [PCT_BITS-1:0]      pct_type;
   typedef logic [LOWER_BITS-1:0]    lower_type;
   typedef logic [SCALE_BITS-1:0]    scale_type;
   typedef logic [PROD_BITS-1:0]     prod_type;
   typedef logic [DIV_BITS-1:0]      div_type;
   typedef logic [DIV_CNT_BITS-1:0]  div_cnt_type;
   typedef logic [CSR_DATA_BITS-1:0] csr_data_type;

   // register indexes
   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_TARGET_COUNT = 2'd0,
      CSR_MAX_SAMPLES  = 2'd1,
      CSR_UPPER_PCT    = 2'd2,
      CSR_LOWER_PCT    = 2'd3
   } csr_index_type;

   // register reset values
   localparam count_type TARGET_RESET = COUNT_BITS'(5);
   localparam taken_type MAX_RESET    = TAKEN_BITS'(25);
   localparam pct_type   UPPER_RESET  = PCT_BITS'(120);
   localparam lower_type LOWER_RESET  = LOWER_BITS'(80);

   // controller states, one-hot
   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_MUL1   = 6'b000010,
      ST_MUL2   = 6'b000100,
      ST_UPDATE = 6'b001000,
      ST_DIVIDE = 6'b010000,
      ST_OUTPUT = 6'b100000
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic take;      // latch the incoming sample
      logic mul_ref;   // form bound*sum products and count*100
      logic mul_smp;   // form sample*count*100 products
      logic update;    // band test, run update, divider load on finish
      logic div_step;  // two quotient bits
      logic out_load;  // move the quotient into the result register
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic finish;    // the measurement completes with this sample
      logic out_free;  // the result register can take a new beat
   } dp_status_type;

endpackage

>>> hdl/orsa_if.sv
// Valid/ready channel interfaces for the sample input and the result output.
// Depends on orsa_pkg.
`timescale 1ns / 1ps

interface orsa_req_if import orsa_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface orsa_rsp_if import orsa_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type average;
   count_type  agree_count;
   logic       timed_out;

   modport source (output valid, output average, output agree_count,
                   output timed_out, input ready);
   modport sink   (input valid, input average, input agree_count,
                   input timed_out, output ready);
endinterface

>>> hdl/outlier_rejecting_sample_average.sv
// Top level of the outlier-rejecting sample average: controller plus datapath.
// Depends on orsa_pkg, orsa_if, orsa_ctrl and orsa_dp.
//
// Usage:
//   req_if carries one converter sample per beat; rsp_if carries one result
//   beat (average, agree_count, timed_out) per finished measurement. The csr_
//   port writes target_count, max_samples, upper_pct and lower_pct by index;
//   write only while the block is idle.
// Sequencing:
//   A sample that does not finish a measurement passes through accept, the
//   multiply states for the band test (ST_MUL1, ST_MUL2) and the update
//   state. A sample that finishes one then goes on through the radix-4
//   divider, which forms sum/count two bits per cycle, and the output state.
//   req_if.ready is high only between samples.
// Reset:
//   Synchronous, active high: registers return to their defaults, the run
//   is cleared and no result beat is pending.
// Back-pressure:
//   A finished beat sits in the result register; the next sample is accepted
//   meanwhile, and only a second finished result waits for rsp_if.ready.
`timescale 1ns / 1ps

module outlier_rejecting_sample_average import orsa_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   orsa_req_if.sink                 req_if,
   orsa_rsp_if.source               rsp_if,
   input  logic                     csr_wr_en,
   input  logic [CSR_ADDR_BITS-1:0] csr_index,
   input  csr_data_type             csr_wr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   orsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   orsa_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .req_sample      (req_if.sample),
      .rsp_ready       (rsp_if.ready),
      .rsp_valid       (rsp_if.valid),
      .rsp_average     (rsp_if.average),
      .rsp_agree_count (rsp_if.agree_count),
      .rsp_timed_out   (rsp_if.timed_out),
      .cmd             (cmd),
      .status          (status)
   );

endmodule

>>> hdl/orsa_ctrl.sv
// Controller for the sample average: sequences the band test, the divider
// iterations and the result hand-off. Depends on orsa_pkg.
`timescale 1ns / 1ps

module orsa_ctrl import orsa_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;
   div_cnt_type    div_cnt_ff, div_cnt_in;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      req_ready  = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            cmd.mul_ref = 1'b1;
            state_in    = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul_smp = 1'b1;
            state_in    = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            div_cnt_in = '0;
            state_in   = status.finish ? ST_DIVIDE : ST_IDLE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (div_cnt_ff == DIV_CNT_BITS'(DIV_CYCLES - 1)) begin
               state_in = ST_OUTPUT;
            end else begin
               div_cnt_in = div_cnt_ff + 1'b1;
            end
         end
         ST_OUTPUT: begin
            // hold the quotient until the result register frees up
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

endmodule

>>> hdl/orsa_dp.sv
// Datapath for the sample average: configuration registers, run state,
// band-test multipliers, radix-4 divider and result register. Depends on orsa_pkg.
`timescale 1ns / 1ps

module orsa_dp import orsa_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // configuration writes
   input  logic                     csr_wr_en,
   input  logic [CSR_ADDR_BITS-1:0] csr_index,
   input  csr_data_type             csr_wr_data,
   // sample and result payload
   input  sample_type               req_sample,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output sample_type               rsp_average,
   output count_type                rsp_agree_count,
   output logic                     rsp_timed_out,
   // controller link
   input  dp_cmd_type               cmd,
   output dp_status_type            status
);

   // configuration
   count_type target_ff;
   taken_type max_ff;
   pct_type   upper_ff;
   lower_type lower_ff;

   // run state
   sum_type   run_sum_ff,   run_sum_in;
   count_type run_count_ff, run_count_in;
   taken_type taken_ff,     taken_in;

   // band test pipeline
   sample_type sample_ff;
   scale_type  scaled_ff;
   prod_type   ref_hi_ff, ref_lo_ff;
   prod_type   smp_hi_ff, smp_lo_ff;
   logic [SAMPLE_BITS:0] sample_p1;

   // divider
   div_type   quo_ff, quo_in;
   count_type rem_ff, rem_in;
   count_type den_ff;
   count_type pend_count_ff;
   logic      pend_timeout_ff;

   // result register
   logic       out_valid_ff, out_valid_in;
   sample_type out_avg_ff;
   count_type  out_count_ff;
   logic       out_timeout_ff;

   // update of the run
   logic      too_high, too_low, restart, reached, spent, finish;
   count_type goal;
   sum_type   upd_sum;
   count_type upd_count;
   taken_type upd_taken;

   // band test and run update
   always_comb begin
      too_high  = smp_hi_ff > ref_hi_ff;
      too_low   = smp_lo_ff <= ref_lo_ff;
      restart   = (run_count_ff == '0) || too_high || too_low;
      upd_sum   = restart ? SUM_BITS'(sample_ff) : run_sum_ff + SUM_BITS'(sample_ff);
      upd_count = restart ? COUNT_BITS'(1) : run_count_ff + 1'b1;
      upd_taken = taken_ff + 1'b1;
      goal      = (target_ff > COUNT_BITS'(RUN_LIMIT)) ? COUNT_BITS'(RUN_LIMIT)
                                                       : target_ff;
      reached   = upd_count >= goal;
      spent     = upd_taken >= max_ff;
      finish    = reached || spent;

      run_sum_in   = run_sum_ff;
      run_count_in = run_count_ff;
      taken_in     = taken_ff;
      if (cmd.update) begin
         if (finish) begin
            run_sum_in   = '0;
            run_count_in = '0;
            taken_in     = '0;
         end else begin
            run_sum_in   = upd_sum;
            run_count_in = upd_count;
            taken_in     = upd_taken;
         end
      end
   end

   assign sample_p1 = {1'b0, sample_ff} + (SAMPLE_BITS + 1)'(1);

   // divider: two restoring steps per cycle, dividend shifts out at the top
   always_comb begin
      logic [COUNT_BITS:0] part;
      div_type             quo;
      count_type           rem;
      quo = quo_ff;
      rem = rem_ff;
      for (int i = 0; i < 2; i++) begin
         part = {rem, quo[DIV_BITS-1]};
         quo  = {quo[DIV_BITS-2:0], 1'b0};
         if (part >= {1'b0, den_ff}) begin
            part   = part - {1'b0, den_ff};
            quo[0] = 1'b1;
         end
         rem = part[COUNT_BITS-1:0];
      end
      quo_in = quo;
      rem_in = rem;
   end

   // status back to the controller: {finish, out_free}
   assign status = {finish, !out_valid_ff || rsp_ready};

   // result register handshake
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= TARGET_RESET;
         max_ff       <= MAX_RESET;
         upper_ff     <= UPPER_RESET;
         lower_ff     <= LOWER_RESET;
         run_sum_ff   <= '0;
         run_count_ff <= '0;
         taken_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_TARGET_COUNT: target_ff <= csr_wr_data[COUNT_BITS-1:0];
               CSR_MAX_SAMPLES:  max_ff    <= csr_wr_data[TAKEN_BITS-1:0];
               CSR_UPPER_PCT:    upper_ff  <= csr_wr_data[PCT_BITS-1:0];
               CSR_LOWER_PCT:    lower_ff  <= csr_wr_data[LOWER_BITS-1:0];
               default:          ;
            endcase
         end
         run_sum_ff   <= run_sum_in;
         run_count_ff <= run_count_in;
         taken_ff     <= taken_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         sample_ff <= req_sample;
      end
      if (cmd.mul_ref) begin
         scaled_ff <= SCALE_BITS'(run_count_ff) * SCALE_BITS'(PCT_SCALE);
         ref_hi_ff <= PROD_BITS'(upper_ff) * PROD_BITS'(run_sum_ff);
         ref_lo_ff <= PROD_BITS'(lower_ff) * PROD_BITS'(run_sum_ff);
      end
      if (cmd.mul_smp) begin
         smp_hi_ff <= PROD_BITS'(sample_ff) * PROD_BITS'(scaled_ff);
         smp_lo_ff <= PROD_BITS'(sample_p1) * PROD_BITS'(scaled_ff);
      end
      if (cmd.update && finish) begin
         quo_ff          <= DIV_BITS'(upd_sum);
         rem_ff          <= '0;
         den_ff          <= upd_count;
         pend_count_ff   <= upd_count;
         pend_timeout_ff <= !reached;
      end else if (cmd.div_step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
      if (cmd.out_load) begin
         out_avg_ff     <= quo_ff[SAMPLE_BITS-1:0];
         out_count_ff   <= pend_count_ff;
         out_timeout_ff <= pend_timeout_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_average     = out_avg_ff;
   assign rsp_agree_count = out_count_ff;
   assign rsp_timed_out   = out_timeout_ff;

endmodule

>>> hdl/orsa_checker.sv
// Port-level checks for the outlier-rejecting sample average, bound to the
// top level. Depends on orsa_pkg.
`timescale 1ns / 1ps

module orsa_checker import orsa_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input sample_type rsp_average,
   input count_type  rsp_agree_count,
   input logic       rsp_timed_out
);

   // one sample at a time: input closes right after a beat
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input stayed open after a sample beat");

   // reset leaves no result pending and the input open
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("state after reset not clean");

   // an averaged run holds one to eight samples
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_agree_count != '0) &&
                    (rsp_agree_count <= COUNT_BITS'(RUN_LIMIT)))
      else $error("agree_count out of range");

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_average) &&
                                  $stable(rsp_agree_count) &&
                                  $stable(rsp_timed_out))
      else $error("result payload changed while stalled");

endmodule

bind outlier_rejecting_sample_average orsa_checker u_orsa_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_if.valid),
   .req_ready       (req_if.ready),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_average     (rsp_if.average),
   .rsp_agree_count (rsp_if.agree_count),
   .rsp_timed_out   (rsp_if.timed_out)
);
